// ===== rtl/fraction_arith_gcd_reduce_assert.svh =====
// assertion macros for the fraction reduce block
// used by fraction_arith_gcd_reduce; no other dependencies
`ifndef FRACTION_ARITH_GCD_REDUCE_ASSERT_SVH
`define FRACTION_ARITH_GCD_REDUCE_ASSERT_SVH

// same-cycle implication
`define FAGR_ASSERT_SAME(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FAGR_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fagr_pkg.sv =====
// shared types and constants of the fraction reduce block
// no dependencies
package fagr_pkg;

  // default operand width and fixed result field widths
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUM_OUT_W         = 33;
  localparam int DEN_OUT_W         = 32;

  // operation codes; the unused code acts as multiply
  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_SUB     = 2'd1,
    OP_MUL     = 2'd2,
    OP_MUL_ALT = 2'd3
  } opcode_t;

endpackage

// ===== rtl/fagr_chan_if.sv =====
// valid/ready channel interfaces of the fraction reduce block
// depends on fagr_pkg
interface fagr_in_if #(
  parameter int OPERAND_WIDTH = fagr_pkg::OPERAND_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic signed [OPERAND_WIDTH-1:0] first_numerator;
  logic signed [OPERAND_WIDTH-1:0] second_numerator;
  logic signed [OPERAND_WIDTH-1:0] first_denominator;
  logic signed [OPERAND_WIDTH-1:0] second_denominator;

  modport source (
    output valid, opcode, first_numerator, second_numerator,
           first_denominator, second_denominator,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_numerator, second_numerator,
           first_denominator, second_denominator,
    output ready
  );
endinterface

interface fagr_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   valid_res;
  logic signed [fagr_pkg::NUM_OUT_W-1:0]  result_numerator;
  logic signed [fagr_pkg::DEN_OUT_W-1:0]  result_denominator;

  modport source (
    output valid, valid_res, result_numerator, result_denominator,
    input  ready
  );
  modport sink (
    input  valid, valid_res, result_numerator, result_denominator,
    output ready
  );
endinterface

// ===== rtl/fraction_arith_gcd_reduce.sv =====
// Fraction add, subtract or multiply with gcd reduction of the result.
// One shared multiplier and one shared subtractor run under a one-hot sequencer.
// Depends on fagr_pkg, fagr_chan_if.sv and fraction_arith_gcd_reduce_assert.svh.
//
// Takes one item at a time (in_chan.ready is high only when idle). With W the operand
// width and M = 2*W+1 the magnitude width, an item with a zero denominator goes straight
// to the done state; any other item takes three multiplies on the shared W x W multiplier,
// the signed sum and the magnitude, a data-dependent binary gcd loop of shift or
// compare-subtract steps on the shared subtractor, then two restoring divisions of M
// quotient bits each on the same subtractor, and a wait in the done state until the
// output register is free to take the result.
// The output register holds a finished result while the next item is being worked on.
`include "fraction_arith_gcd_reduce_assert.svh"

module fraction_arith_gcd_reduce #(
  parameter int OPERAND_WIDTH = fagr_pkg::OPERAND_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fagr_in_if.sink     in_chan,
  fagr_out_if.source  out_chan
);

  localparam int W     = OPERAND_WIDTH;
  localparam int MAGW  = 2 * W + 1;
  localparam int SW    = MAGW + 1;
  localparam int CNT_W = $clog2(MAGW + 1);
  localparam int EXTW  = (MAGW + 1 > fagr_pkg::NUM_OUT_W) ? MAGW + 1 : fagr_pkg::NUM_OUT_W;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_MUL_DEN = 10'b00_0000_0010,
    ST_MUL_T1  = 10'b00_0000_0100,
    ST_MUL_T2  = 10'b00_0000_1000,
    ST_SUM     = 10'b00_0001_0000,
    ST_ABS     = 10'b00_0010_0000,
    ST_GCD     = 10'b00_0100_0000,
    ST_DIV_N   = 10'b00_1000_0000,
    ST_DIV_D   = 10'b01_0000_0000,
    ST_DONE    = 10'b10_0000_0000
  } state_t;

  // control
  state_t           state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // captured operands
  logic [1:0]   opc_r, opc_nxt;
  logic [W-1:0] n1m_r, n1m_nxt, n2m_r, n2m_nxt, d1m_r, d1m_nxt, d2m_r, d2m_nxt;
  logic         n1s_r, n1s_nxt, n2s_r, n2s_nxt, d1s_r, d1s_nxt, d2s_r, d2s_nxt;
  logic         zero_den_r, zero_den_nxt;

  // working values
  logic [MAGW-1:0]        den_mag_r, den_mag_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  logic signed [SW-1:0]   sum_r, sum_nxt;
  logic                   num_neg_r, num_neg_nxt;
  logic [MAGW-1:0]        a_r, a_nxt, b_r, b_nxt, numv_r, numv_nxt, denv_r, denv_nxt;
  logic [MAGW-1:0]        g_r, g_nxt, q_r, q_nxt, rem_r, rem_nxt, numq_r, numq_nxt;

  // output register
  logic                              res_ok_r, res_ok_nxt;
  logic [fagr_pkg::NUM_OUT_W-1:0]    res_num_r, res_num_nxt;
  logic [fagr_pkg::DEN_OUT_W-1:0]    res_den_r, res_den_nxt;

  // shared units
  logic [W-1:0]      mul_x, mul_y;
  logic [2*W-1:0]    mul_p;
  logic [MAGW:0]     sub_x, sub_y;
  logic [MAGW+1:0]   sub_d;
  logic              borrow;

  // operand capture helpers
  logic [W-1:0] raw_n1, raw_n2, raw_d1, raw_d2;
  logic         in_fire, out_free, mul_mode, sub_mode;
  logic signed [SW-1:0] term1, term2, ext1, ext2, neg_sum;
  logic [EXTW-1:0] num_ext, den_ext, num_bits, den_bits;

  assign raw_n1 = in_chan.first_numerator;
  assign raw_n2 = in_chan.second_numerator;
  assign raw_d1 = in_chan.first_denominator;
  assign raw_d2 = in_chan.second_denominator;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign mul_mode = (opc_r == fagr_pkg::OP_MUL) || (opc_r == fagr_pkg::OP_MUL_ALT);
  assign sub_mode = (opc_r == fagr_pkg::OP_SUB);

  // shared multiplier, operands chosen by state
  always_comb begin
    mul_x = d1m_r;
    mul_y = d2m_r;
    case (state_r)
      ST_MUL_T1: begin
        mul_x = n1m_r;
        mul_y = mul_mode ? n2m_r : d2m_r;
      end
      ST_MUL_T2: begin
        mul_x = d1m_r;
        mul_y = n2m_r;
      end
      default: begin
        mul_x = d1m_r;
        mul_y = d2m_r;
      end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  // shared subtractor: gcd compare-subtract or division trial
  always_comb begin
    case (state_r)
      ST_DIV_N, ST_DIV_D: begin
        sub_x = {rem_r, q_r[MAGW-1]};
        sub_y = {1'b0, g_r};
      end
      default: begin
        sub_x = {1'b0, a_r};
        sub_y = {1'b0, b_r};
      end
    endcase
  end
  assign sub_d  = {1'b0, sub_x} - {1'b0, sub_y};
  assign borrow = sub_d[MAGW+1];

  // signed terms of the numerator sum
  assign ext1    = SW'(t1_r);
  assign ext2    = SW'(t2_r);
  assign term1   = (n1s_r ^ (mul_mode ? n2s_r : d2s_r)) ? -ext1 : ext1;
  assign term2   = mul_mode ? '0 : (((d1s_r ^ n2s_r) ^ sub_mode) ? -ext2 : ext2);
  assign neg_sum = -sum_r;

  // two's complement result fields
  assign num_ext  = EXTW'(numq_r);
  assign den_ext  = EXTW'(q_r);
  assign num_bits = num_neg_r ? (~num_ext + 1'b1) : num_ext;
  assign den_bits = (d1s_r ^ d2s_r) ? (~den_ext + 1'b1) : den_ext;

  // sequencer and datapath next state
  always_comb begin
    state_nxt    = state_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt      = cnt_r;
    opc_nxt      = opc_r;
    n1m_nxt      = n1m_r;
    n2m_nxt      = n2m_r;
    d1m_nxt      = d1m_r;
    d2m_nxt      = d2m_r;
    n1s_nxt      = n1s_r;
    n2s_nxt      = n2s_r;
    d1s_nxt      = d1s_r;
    d2s_nxt      = d2s_r;
    zero_den_nxt = zero_den_r;
    den_mag_nxt  = den_mag_r;
    t1_nxt       = t1_r;
    t2_nxt       = t2_r;
    sum_nxt      = sum_r;
    num_neg_nxt  = num_neg_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    numv_nxt     = numv_r;
    denv_nxt     = denv_r;
    g_nxt        = g_r;
    q_nxt        = q_r;
    rem_nxt      = rem_r;
    numq_nxt     = numq_r;
    res_ok_nxt   = res_ok_r;
    res_num_nxt  = res_num_r;
    res_den_nxt  = res_den_r;

    // output transfer frees the register
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          opc_nxt      = in_chan.opcode;
          n1s_nxt      = raw_n1[W-1];
          n2s_nxt      = raw_n2[W-1];
          d1s_nxt      = raw_d1[W-1];
          d2s_nxt      = raw_d2[W-1];
          n1m_nxt      = raw_n1[W-1] ? (~raw_n1 + 1'b1) : raw_n1;
          n2m_nxt      = raw_n2[W-1] ? (~raw_n2 + 1'b1) : raw_n2;
          d1m_nxt      = raw_d1[W-1] ? (~raw_d1 + 1'b1) : raw_d1;
          d2m_nxt      = raw_d2[W-1] ? (~raw_d2 + 1'b1) : raw_d2;
          zero_den_nxt = (raw_d1 == '0) || (raw_d2 == '0);
          state_nxt    = ((raw_d1 == '0) || (raw_d2 == '0)) ? ST_DONE : ST_MUL_DEN;
        end
      end
      ST_MUL_DEN: begin
        den_mag_nxt = MAGW'(mul_p);
        state_nxt   = ST_MUL_T1;
      end
      ST_MUL_T1: begin
        t1_nxt    = MAGW'(mul_p);
        state_nxt = ST_MUL_T2;
      end
      ST_MUL_T2: begin
        t2_nxt    = MAGW'(mul_p);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sum_nxt   = term1 + term2;
        state_nxt = ST_ABS;
      end
      // split sign from magnitude and seed the gcd loop
      ST_ABS: begin
        num_neg_nxt = sum_r[SW-1];
        a_nxt       = sum_r[SW-1] ? neg_sum[MAGW-1:0] : sum_r[MAGW-1:0];
        numv_nxt    = sum_r[SW-1] ? neg_sum[MAGW-1:0] : sum_r[MAGW-1:0];
        b_nxt       = den_mag_r;
        denv_nxt    = den_mag_r;
        state_nxt   = ST_GCD;
      end
      // binary gcd; common factors of two are taken out of both values directly
      ST_GCD: begin
        if (a_r == '0) begin
          g_nxt     = b_r;
          q_nxt     = numv_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV_N;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt    = a_r >> 1;
          b_nxt    = b_r >> 1;
          numv_nxt = numv_r >> 1;
          denv_nxt = denv_r >> 1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (borrow) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          a_nxt = sub_d[MAGW-1:0];
        end
      end
      // restoring division, one quotient bit per cycle
      ST_DIV_N, ST_DIV_D: begin
        q_nxt   = {q_r[MAGW-2:0], ~borrow};
        rem_nxt = borrow ? sub_x[MAGW-1:0] : sub_d[MAGW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAGW - 1)) begin
          cnt_nxt = '0;
          if (state_r == ST_DIV_N) begin
            numq_nxt  = {q_r[MAGW-2:0], ~borrow};
            q_nxt     = denv_r;
            rem_nxt   = '0;
            state_nxt = ST_DIV_D;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      // load the output register once it is free
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_ok_nxt    = !zero_den_r;
          res_num_nxt   = zero_den_r ? '0 : num_bits[fagr_pkg::NUM_OUT_W-1:0];
          res_den_nxt   = zero_den_r ? '0 : den_bits[fagr_pkg::DEN_OUT_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    opc_r      <= opc_nxt;
    n1m_r      <= n1m_nxt;
    n2m_r      <= n2m_nxt;
    d1m_r      <= d1m_nxt;
    d2m_r      <= d2m_nxt;
    n1s_r      <= n1s_nxt;
    n2s_r      <= n2s_nxt;
    d1s_r      <= d1s_nxt;
    d2s_r      <= d2s_nxt;
    zero_den_r <= zero_den_nxt;
    den_mag_r  <= den_mag_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    sum_r      <= sum_nxt;
    num_neg_r  <= num_neg_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    numv_r     <= numv_nxt;
    denv_r     <= denv_nxt;
    g_r        <= g_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    numq_r     <= numq_nxt;
    res_ok_r   <= res_ok_nxt;
    res_num_r  <= res_num_nxt;
    res_den_r  <= res_den_nxt;
  end

  // result channel
  assign out_chan.valid              = out_valid_r;
  assign out_chan.valid_res          = res_ok_r;
  assign out_chan.result_numerator   = res_num_r;
  assign out_chan.result_denominator = res_den_r;

  // checks
  `FAGR_ASSERT_NEXT(a_zero_den_skips, clk, rst_n,
    in_fire && ((raw_d1 == '0) || (raw_d2 == '0)), state_r == ST_DONE,
    "zero denominator item did not go straight to done")
  `FAGR_ASSERT_SAME(a_div_nonzero, clk, rst_n,
    (state_r == ST_DIV_N) || (state_r == ST_DIV_D), g_r != '0,
    "division started with a zero gcd")
  `FAGR_ASSERT_NEXT(a_done_loads, clk, rst_n,
    (state_r == ST_DONE) && out_free, out_valid_r && (state_r == ST_IDLE),
    "finished result not loaded into the output register")

endmodule

// ===== tb/tb_fraction_arith_gcd_reduce.sv =====
// self-checking testbench for fraction_arith_gcd_reduce: fraction add, subtract and
// multiply with gcd reduction, checked against an in-bench predictor
// depends on fagr_pkg, fagr_chan_if.sv and the block's rtl
`timescale 1ns / 1ps

module tb_fraction_arith_gcd_reduce;

  localparam int W            = fagr_pkg::OPERAND_WIDTH_DEF;
  localparam int RANDOM_SETS  = 1250;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    fagr_pkg::opcode_t     op;
    logic signed [W-1:0]   n1;
    logic signed [W-1:0]   n2;
    logic signed [W-1:0]   d1;
    logic signed [W-1:0]   d2;
  } operand_set_t;

  typedef struct {
    logic                            ok;
    logic [fagr_pkg::NUM_OUT_W-1:0]  num;
    logic [fagr_pkg::DEN_OUT_W-1:0]  den;
  } reduced_t;

  logic clk;
  logic rst_n;

  fagr_in_if #(.OPERAND_WIDTH(W)) in_chan ();
  fagr_out_if out_chan ();

  fraction_arith_gcd_reduce #(.OPERAND_WIDTH(W)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  operand_set_t operand_sets[$];
  reduced_t     expected_fractions[$];
  int           sets_total;
  int           sets_taken;
  int           mismatch_count;
  int           idle_cycles;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // exact rational result, reduced by the gcd of the magnitudes
  function automatic reduced_t reduce_fraction(operand_set_t s);
    reduced_t r;
    longint   top, bottom, x, y, t;
    if (s.d1 == 0 || s.d2 == 0) begin
      r.ok  = 1'b0;
      r.num = '0;
      r.den = '0;
      return r;
    end
    bottom = longint'(s.d1) * longint'(s.d2);
    if (s.op == fagr_pkg::OP_MUL || s.op == fagr_pkg::OP_MUL_ALT) begin
      top = longint'(s.n1) * longint'(s.n2);
    end else if (s.op == fagr_pkg::OP_SUB) begin
      top = longint'(s.n1) * longint'(s.d2) - longint'(s.d1) * longint'(s.n2);
    end else begin
      top = longint'(s.n1) * longint'(s.d2) + longint'(s.d1) * longint'(s.n2);
    end
    // euclid on absolute values
    x = (top < 0) ? -top : top;
    y = (bottom < 0) ? -bottom : bottom;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x != 0) begin
      top    = top / x;
      bottom = bottom / x;
    end
    r.ok  = 1'b1;
    r.num = top[fagr_pkg::NUM_OUT_W-1:0];
    r.den = bottom[fagr_pkg::DEN_OUT_W-1:0];
    return r;
  endfunction

  // operand value mix: full range, small values, extremes, shared factors
  function automatic logic signed [W-1:0] draw_operand();
    logic signed [W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = W'($urandom);
      4, 5, 6:    v = W'($signed($urandom_range(0, 40)) - 20);
      7: begin
        case ($urandom_range(0, 4))
          0:       v = {1'b1, {(W-1){1'b0}}};
          1:       v = {1'b0, {(W-1){1'b1}}};
          2:       v = '1;
          3:       v = W'(1);
          default: v = {1'b1, {(W-2){1'b0}}, 1'b1};
        endcase
      end
      8:       v = W'(($signed($urandom_range(0, 30)) - 15) <<< $urandom_range(0, 10));
      default: v = W'(($signed($urandom_range(0, 60)) - 30) * (3 * $urandom_range(1, 300)));
    endcase
    return v;
  endfunction

  function automatic logic signed [W-1:0] draw_denominator();
    if ($urandom_range(0, 19) == 0) return '0;
    return draw_operand();
  endfunction

  function automatic int draw_pause(bit quiet);
    if (quiet) return 0;
    return $urandom_range(0, 15);
  endfunction

  task automatic add_set(fagr_pkg::opcode_t op, int n1, int d1, int n2, int d2);
    operand_set_t s;
    s.op = op;
    s.n1 = n1[W-1:0];
    s.d1 = d1[W-1:0];
    s.n2 = n2[W-1:0];
    s.d2 = d2[W-1:0];
    operand_sets.push_back(s);
  endtask

  // input driver
  int           src_pause;
  int           src_hold;
  bit           src_quiet;
  operand_set_t src_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      src_pause     <= 0;
      src_quiet     <= 1'b0;
    end else begin
      // record the prediction on each transfer
      if (in_chan.valid && in_chan.ready) begin
        src_next.op = fagr_pkg::opcode_t'(in_chan.opcode);
        src_next.n1 = in_chan.first_numerator;
        src_next.n2 = in_chan.second_numerator;
        src_next.d1 = in_chan.first_denominator;
        src_next.d2 = in_chan.second_denominator;
        expected_fractions.push_back(reduce_fraction(src_next));
        sets_taken++;
      end
      // present the next set once the slot is free and the pause is over
      if (!in_chan.valid || in_chan.ready) begin
        if (src_pause != 0) begin
          in_chan.valid <= 1'b0;
          src_pause     <= src_pause - 1;
        end else if (operand_sets.size() != 0) begin
          src_next                   = operand_sets.pop_front();
          in_chan.opcode             <= src_next.op;
          in_chan.first_numerator    <= src_next.n1;
          in_chan.second_numerator   <= src_next.n2;
          in_chan.first_denominator  <= src_next.d1;
          in_chan.second_denominator <= src_next.d2;
          in_chan.valid              <= 1'b1;
          if ($urandom_range(0, 39) == 0) src_quiet <= ~src_quiet;
          src_hold  = draw_pause(src_quiet);
          src_pause <= src_hold;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  int       sink_pause;
  int       sink_hold;
  bit       sink_quiet;
  reduced_t sink_want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      sink_pause     <= 0;
      sink_quiet     <= 1'b0;
    end else begin
      sink_hold = sink_pause;
      if (out_chan.valid && out_chan.ready) begin
        if (expected_fractions.size() == 0) begin
          $display("%0t: unexpected result valid_res=%0b num=%0d den=%0d", $time,
                   out_chan.valid_res, out_chan.result_numerator,
                   out_chan.result_denominator);
          mismatch_count++;
        end else begin
          sink_want = expected_fractions.pop_front();
          if (out_chan.valid_res !== sink_want.ok) begin
            $display("%0t: valid_res expected %0b actual %0b", $time, sink_want.ok,
                     out_chan.valid_res);
            mismatch_count++;
          end
          if (out_chan.result_numerator !== sink_want.num) begin
            $display("%0t: result_numerator expected %0d actual %0d", $time,
                     $signed(sink_want.num), out_chan.result_numerator);
            mismatch_count++;
          end
          if (out_chan.result_denominator !== sink_want.den) begin
            $display("%0t: result_denominator expected %0d actual %0d", $time,
                     $signed(sink_want.den), out_chan.result_denominator);
            mismatch_count++;
          end
        end
        if ($urandom_range(0, 29) == 0) sink_quiet <= ~sink_quiet;
        sink_hold = draw_pause(sink_quiet);
      end
      if (sink_hold != 0) begin
        out_chan.ready <= 1'b0;
        sink_pause     <= sink_hold - 1;
      end else begin
        out_chan.ready <= 1'b1;
        sink_pause     <= 0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, stimulus and end of run
  initial begin
    rst_n                      = 1'b0;
    in_chan.valid              = 1'b0;
    in_chan.opcode             = fagr_pkg::OP_ADD;
    in_chan.first_numerator    = '0;
    in_chan.second_numerator   = '0;
    in_chan.first_denominator  = '0;
    in_chan.second_denominator = '0;
    out_chan.ready             = 1'b0;
    sets_taken                 = 0;
    mismatch_count             = 0;
    idle_cycles                = 0;

    // directed sets: ordinary cases, zero results, extremes, zero denominators
    add_set(fagr_pkg::OP_ADD,          1,      2,      1,      3);
    add_set(fagr_pkg::OP_SUB,          1,      2,      1,      2);
    add_set(fagr_pkg::OP_MUL,          0,     -3,      5,      7);
    add_set(fagr_pkg::OP_SUB,          3,     -4,      3,     -4);
    add_set(fagr_pkg::OP_MUL,     -32768, -32768, -32768, -32768);
    add_set(fagr_pkg::OP_ADD,     -32768, -32768, -32768, -32768);
    add_set(fagr_pkg::OP_ADD,     -32768,  32767, -32768,  32765);
    add_set(fagr_pkg::OP_SUB,      32767, -32768, -32768,  32767);
    add_set(fagr_pkg::OP_ADD,      32767,  32767,  32767, -32768);
    add_set(fagr_pkg::OP_MUL,      32767,  32766,  32765,  32767);
    add_set(fagr_pkg::OP_MUL_ALT,      6,     -9,      4,     10);
    add_set(fagr_pkg::OP_MUL_ALT,     -1,      1,     -1,     -1);
    add_set(fagr_pkg::OP_ADD,          5,      0,      1,      3);
    add_set(fagr_pkg::OP_SUB,          5,      7,      1,      0);
    add_set(fagr_pkg::OP_MUL,          0,      0,      0,      0);
    add_set(fagr_pkg::OP_MUL_ALT,      1,      0,      1,      0);
    add_set(fagr_pkg::OP_ADD,         -1,     -1,     -1,     -1);
    add_set(fagr_pkg::OP_SUB,         12,     18,    -20,     30);
    add_set(fagr_pkg::OP_ADD,          0,      5,      0,     -5);
    add_set(fagr_pkg::OP_MUL,      -7680,   2048,   1024,  -4096);
    add_set(fagr_pkg::OP_SUB,     -21845,  21846,  10922, -10923);

    // random sets
    for (int i = 0; i < RANDOM_SETS; i++) begin
      operand_set_t s;
      s.op = fagr_pkg::opcode_t'($urandom_range(0, 3));
      s.n1 = draw_operand();
      s.n2 = draw_operand();
      s.d1 = draw_denominator();
      s.d2 = draw_denominator();
      operand_sets.push_back(s);
    end
    sets_total = operand_sets.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (sets_taken < sets_total) @(posedge clk);
    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_fractions.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
